/* hdl/crfc_pkg.sv */
// ----------------------------------------------------------------------------
// crfc_pkg
// Types, constants and the CRC byte update shared by the CRC-32 record
// framer and checker.
// ----------------------------------------------------------------------------
package crfc_pkg;

    localparam int ADDR_W      = 10;
    localparam int POS_W       = 11;
    localparam int SUM_W       = 12;
    localparam int QUO_W       = 8;
    localparam int IDX_W       = 3;
    localparam int CRC_BYTES   = 4;
    localparam int RECIP_SHIFT = 24;

    localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
    localparam logic [31:0] CRC_FINAL_XOR = 32'hFFFF_FFFF;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [ADDR_W-1:0] record_base;
        logic [7:0]        data_byte;
        logic              last;
    } t_in;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [7:0]        out_byte;
        logic              is_crc_byte;
        logic              check_done;
        logic              crc_ok;
        logic              last_out;
    } t_out;

    typedef struct packed {
        logic [SUM_W-1:0]  addr_sum;
        logic [QUO_W-1:0]  addr_quo;
        logic [ADDR_W-1:0] base;
        logic [QUO_W-1:0]  base_quo;
        logic [7:0]        data_byte;
        logic              is_crc;
        logic              check_done;
        logic              crc_ok;
        logic              burst;
        logic [31:0]       fin;
    } t_mid;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [7:0]        data_byte;
        logic              is_crc;
        logic              check_done;
        logic              crc_ok;
        logic              burst;
        logic [ADDR_W-1:0] base_mod;
        logic [31:0]       fin;
    } t_res;

    // reflected crc-32, one byte
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] r;
        r = crc ^ {24'h0, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

/* hdl/crfc_frame.sv */
// ----------------------------------------------------------------------------
// crfc_frame
// Request register, record state (CRC register, byte position, stored
// checksum) and per-byte framing, with the quotient estimates for the
// address wrap registered alongside.
// ----------------------------------------------------------------------------
module crfc_frame
    import crfc_pkg::*;
#(
    parameter int STORE_BYTES = 1024
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_mid_valid,
    input  logic i_mid_ready,
    output t_mid o_mid
);

    localparam logic [31:0] RECIP = 32'((32'd1 << RECIP_SHIFT) / STORE_BYTES);

    logic             r_in_v;
    t_in              r_in;
    logic             r_mid_v;
    t_mid             r_mid;
    logic [31:0]      r_crc;
    logic [POS_W-1:0] r_pos;
    logic [31:0]      r_stored;

    logic             adv;
    logic             in_chk;
    logic             rd;
    logic [31:0]      crc_upd;
    logic [31:0]      n_crc;
    logic [31:0]      n_stored;
    logic [SUM_W-1:0] sum;
    logic [31:0]      prod_a;
    logic [31:0]      prod_b;
    t_mid             n_mid;

    assign adv        = r_in_v && (!r_mid_v || i_mid_ready);
    assign o_in_ready = !r_in_v || adv;

    always_comb begin
        rd       = (r_in.req_type == REQ_READ);
        in_chk   = (r_pos < POS_W'(CRC_BYTES));
        crc_upd  = crc32_byte(r_crc, r_in.data_byte);
        n_stored = r_stored;
        if (rd && in_chk) begin
            n_stored[{r_pos[1:0], 3'b000} +: 8] = r_in.data_byte;
        end
        n_crc = (rd && in_chk) ? r_crc : crc_upd;
        sum   = SUM_W'(r_in.record_base) + SUM_W'(r_pos);
        if (!rd) begin
            sum = sum + SUM_W'(CRC_BYTES);
        end
        prod_a = 32'(sum) * RECIP;
        prod_b = 32'(r_in.record_base) * RECIP;

        n_mid.addr_sum   = sum;
        n_mid.addr_quo   = prod_a[RECIP_SHIFT +: QUO_W];
        n_mid.base       = r_in.record_base;
        n_mid.base_quo   = prod_b[RECIP_SHIFT +: QUO_W];
        n_mid.data_byte  = r_in.data_byte;
        n_mid.is_crc     = rd && in_chk;
        n_mid.check_done = rd && r_in.last;
        n_mid.crc_ok     = rd && r_in.last && ((n_crc ^ CRC_FINAL_XOR) == n_stored);
        n_mid.burst      = !rd && r_in.last;
        n_mid.fin        = n_crc ^ CRC_FINAL_XOR;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v   <= 1'b0;
            r_mid_v  <= 1'b0;
            r_crc    <= '0;
            r_pos    <= '0;
            r_stored <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_v <= i_in_valid;
            end
            if (adv) begin
                r_mid_v <= 1'b1;
            end else if (i_mid_ready) begin
                r_mid_v <= 1'b0;
            end
            if (adv) begin
                if (r_in.last) begin
                    r_crc    <= '0;
                    r_pos    <= '0;
                    r_stored <= '0;
                end else begin
                    r_crc    <= n_crc;
                    r_pos    <= r_pos + POS_W'(1);
                    r_stored <= n_stored;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
        if (adv) begin
            r_mid <= n_mid;
        end
    end

    assign o_mid_valid = r_mid_v;
    assign o_mid       = r_mid;

endmodule

/* hdl/crfc_wrap.sv */
// ----------------------------------------------------------------------------
// crfc_wrap
// Reduces the data address and the record base modulo the store size from
// the registered quotient estimates: one subtract and one corrective step.
// ----------------------------------------------------------------------------
module crfc_wrap
    import crfc_pkg::*;
#(
    parameter int STORE_BYTES = 1024
) (
    input  t_mid i_mid,
    output t_res o_res
);

    localparam int CW = ($clog2(STORE_BYTES + 1) > SUM_W) ? $clog2(STORE_BYTES + 1) : SUM_W + 1;
    localparam logic [CW-1:0]    STORE_C = CW'(STORE_BYTES);
    localparam logic [SUM_W-1:0] STORE_S = SUM_W'(STORE_BYTES);

    logic [SUM_W-1:0] ra;
    logic [SUM_W-1:0] rb;

    always_comb begin
        ra = i_mid.addr_sum - SUM_W'(SUM_W'(i_mid.addr_quo) * STORE_S);
        if (CW'(ra) >= STORE_C) begin
            ra = ra - STORE_S;
        end
        rb = SUM_W'(i_mid.base) - SUM_W'(SUM_W'(i_mid.base_quo) * STORE_S);
        if (CW'(rb) >= STORE_C) begin
            rb = rb - STORE_S;
        end

        o_res.address    = ra[ADDR_W-1:0];
        o_res.data_byte  = i_mid.data_byte;
        o_res.is_crc     = i_mid.is_crc;
        o_res.check_done = i_mid.check_done;
        o_res.crc_ok     = i_mid.crc_ok;
        o_res.burst      = i_mid.burst;
        o_res.base_mod   = rb[ADDR_W-1:0];
        o_res.fin        = i_mid.fin;
    end

endmodule

/* hdl/crfc_emit.sv */
// ----------------------------------------------------------------------------
// crfc_emit
// Result register; sends the byte result and, after a write that ends a
// record, the four checksum bytes least significant first.
// ----------------------------------------------------------------------------
module crfc_emit
    import crfc_pkg::*;
#(
    parameter int STORE_BYTES = 1024
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_res_valid,
    output logic o_res_ready,
    input  t_res i_res,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    localparam int AW1 = ADDR_W + 1;
    localparam int CW  = ($clog2(STORE_BYTES + 1) > AW1) ? $clog2(STORE_BYTES + 1) : AW1 + 1;
    localparam logic [CW-1:0]    STORE_C  = CW'(STORE_BYTES);
    localparam logic [AW1-1:0]   STORE_A  = AW1'(STORE_BYTES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CRC_BYTES);

    logic             r_res_v;
    t_res             r_res;
    logic [IDX_W-1:0] r_idx;

    logic             fire;
    logic             is_final;
    logic             done;
    logic             load;
    logic [1:0]       sel;
    logic [AW1-1:0]   crc_addr;

    assign fire        = r_res_v && i_out_ready;
    assign is_final    = !r_res.burst || (r_idx == IDX_LAST);
    assign done        = fire && is_final;
    assign o_res_ready = !r_res_v || done;
    assign load        = i_res_valid && o_res_ready;

    always_comb begin
        sel      = 2'(r_idx - IDX_W'(1));
        crc_addr = AW1'(r_res.base_mod) + AW1'(sel);
        if (CW'(crc_addr) >= STORE_C) begin
            crc_addr = crc_addr - STORE_A;
        end
        if (r_idx == '0) begin
            o_out.address     = r_res.address;
            o_out.out_byte    = r_res.data_byte;
            o_out.is_crc_byte = r_res.is_crc;
            o_out.check_done  = r_res.check_done;
            o_out.crc_ok      = r_res.crc_ok;
            o_out.last_out    = !r_res.burst;
        end else begin
            o_out.address     = crc_addr[ADDR_W-1:0];
            o_out.out_byte    = r_res.fin[{sel, 3'b000} +: 8];
            o_out.is_crc_byte = 1'b1;
            o_out.check_done  = 1'b0;
            o_out.crc_ok      = 1'b0;
            o_out.last_out    = (r_idx == IDX_LAST);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_v <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_res_v <= 1'b1;
            r_idx   <= '0;
        end else if (done) begin
            r_res_v <= 1'b0;
            r_idx   <= '0;
        end else if (fire) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid = r_res_v;

endmodule

/* hdl/crc32_record_framer_checker.sv */
// ----------------------------------------------------------------------------
// crc32_record_framer_checker
// Frames and checks CRC-32 protected records in a byte store.
// ----------------------------------------------------------------------------
// A new request is taken every cycle unless stalled and gives one result; a
// write request that ends a record gives five: the data byte and then the four
// checksum bytes at base..base+3, least significant first. The single result
// register sends one result per cycle while i_out_ready is set, so such a
// request holds the output for all five results and the input stalls behind it
// once the request and framing registers are full. The CRC-32 (reflected,
// starting from zero, inverted at the end) is updated with each data byte; all
// addresses wrap at STORE_BYTES. In read mode the four stored checksum bytes
// come first and crc_ok is valid with check_done on the record's last byte.
// ----------------------------------------------------------------------------
module crc32_record_framer_checker
    import crfc_pkg::*;
#(
    parameter int STORE_BYTES = 1024
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    logic mid_valid;
    logic mid_ready;
    t_mid mid;
    t_res res;

    crfc_frame #(
        .STORE_BYTES(STORE_BYTES)
    ) u_frame (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_mid_valid(mid_valid),
        .i_mid_ready(mid_ready),
        .o_mid      (mid)
    );

    crfc_wrap #(
        .STORE_BYTES(STORE_BYTES)
    ) u_wrap (
        .i_mid(mid),
        .o_res(res)
    );

    crfc_emit #(
        .STORE_BYTES(STORE_BYTES)
    ) u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_res_valid(mid_valid),
        .o_res_ready(mid_ready),
        .i_res      (res),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out)
    );

endmodule

/* hdl/crfc_checker.sv */
// ----------------------------------------------------------------------------
// crfc_checker
// Port-level checks for the CRC-32 record framer and checker.
// ----------------------------------------------------------------------------
module crfc_checker
    import crfc_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_in  i_in,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out
);

    // request held while stalled
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in))
        else $error("request changed while stalled");

    // result held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_ok_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.crc_ok |-> o_out.check_done && o_out.last_out)
        else $error("crc_ok without check_done");

    // a result that is not the last of its request is followed by checksum bytes
    a_burst_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out.last_out |=> o_out_valid && o_out.is_crc_byte)
        else $error("checksum byte missing in burst");

endmodule

bind crc32_record_framer_checker crfc_checker u_crfc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_ready (o_in_ready),
    .i_in       (i_in),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out      (o_out)
);
